// ----- rtl/mrrt_pkg.sv -----
// Shared types, constants and codes for the memory region reserve table.
// Used by the table cell, the controller, the top level and the testbench.
package mrrt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W = 64;
    localparam int KIND_W = 8;

    localparam logic [KIND_W-1:0] KIND_AVAILABLE = 8'd1;
    localparam logic [KIND_W-1:0] KIND_RESERVED = 8'd0;

    typedef enum logic [1:0] {
        CMD_APPEND  = 2'd0,
        CMD_RESERVE = 2'd1,
        CMD_READ    = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_FULL      = 2'd2,
        ST_IDX_RANGE = 2'd3
    } status_t;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] length;
        logic [KIND_W-1:0] kind;
        logic [ADDR_W:0]   end_addr;
    } entry_t;

    typedef struct packed {
        logic   hit;
        idx_t   idx;
        entry_t ent;
    } scan_t;

    typedef struct packed {
        logic              is_read;
        idx_t              rd_idx;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W:0]   end_addr;
        cnt_t              count;
    } query_t;

    typedef struct packed {
        logic   en;
        idx_t   idx;
        entry_t ent;
    } write_t;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_EXEC     = 7'b0000010,
        S_SCAN     = 7'b0000100,
        S_WR_LOW   = 7'b0001000,
        S_WR_HIGH  = 7'b0010000,
        S_WR_FOUND = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

endpackage

// ----- rtl/mrrt_if.sv -----
// Handshake channels of the memory region reserve table: command items in, result items out.
// Depends on nothing.
interface mrrt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [63:0] range_base;
    logic [63:0] range_length;
    logic [7:0]  region_kind;
    logic [3:0]  entry_index;

    modport source (output valid, cmd, range_base, range_length, region_kind, entry_index,
                    input ready);
    modport sink (input valid, cmd, range_base, range_length, region_kind, entry_index,
                  output ready);
endinterface

interface mrrt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [4:0]  entry_count;
    logic [63:0] out_base;
    logic [63:0] out_length;
    logic [7:0]  out_kind;
    logic [63:0] top_addr;

    modport source (output valid, status, entry_count, out_base, out_length, out_kind, top_addr,
                    input ready);
    modport sink (input valid, status, entry_count, out_base, out_length, out_kind, top_addr,
                  output ready);
endinterface

// ----- rtl/mrrt_cell.sv -----
// One table cell: holds one region entry and one stage of the scan chain.
// Depends on mrrt_pkg.
module mrrt_cell
    import mrrt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  idx_t   cell_idx,
    input  query_t query,
    input  write_t wr,
    input  logic   scan_in_valid,
    input  scan_t  scan_in,
    output logic   scan_out_valid,
    output scan_t  scan_out
);

    entry_t ent_reg;
    logic   valid_reg;
    scan_t  scan_reg;
    scan_t  scan_next;
    logic   in_table;
    logic   fits;
    logic   selected;

    always_comb
    begin
        in_table = CNT_W'(cell_idx) < query.count;
        fits = (ent_reg.kind == KIND_AVAILABLE) && (ent_reg.base <= query.start) &&
               (query.end_addr <= ent_reg.end_addr);
        selected = query.is_read ? (cell_idx == query.rd_idx) : fits;
        scan_next = scan_in;
        if (in_table && selected && !scan_in.hit)
        begin
            scan_next.hit = 1'b1;
            scan_next.idx = cell_idx;
            scan_next.ent = ent_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.idx == cell_idx))
        begin
            ent_reg <= wr.ent;
        end
        scan_reg <= scan_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= scan_in_valid;
        end
    end

    assign scan_out_valid = valid_reg;
    assign scan_out = scan_reg;

endmodule

// ----- rtl/mrrt_ctrl.sv -----
// Command sequencer: takes items, drives the scan chain and the table writes, holds the result.
// Depends on mrrt_pkg and the channel interfaces in mrrt_if.
module mrrt_ctrl
    import mrrt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    mrrt_req_if.sink   req,
    mrrt_rsp_if.source rsp,
    output query_t query,
    output write_t wr,
    output logic   scan_start,
    output scan_t  scan_seed,
    input  logic   scan_done,
    input  scan_t  scan_result
);

    state_t            state_reg, state_next;
    cmd_t              cmd_reg;
    logic [ADDR_W-1:0] start_reg;
    logic [ADDR_W-1:0] len_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [3:0]        rd_idx_reg;
    logic [ADDR_W:0]   req_end_reg;
    cnt_t              count_reg, count_next;
    logic [ADDR_W-1:0] top_reg, top_next;
    status_t           res_status_reg, res_status_next;
    entry_t            res_ent_reg, res_ent_next;
    scan_t             found_reg;
    logic [ADDR_W-1:0] low_len_reg;
    logic [ADDR_W-1:0] high_len_reg;
    logic              need_high_reg;
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg;
    logic [4:0]        out_count_reg;
    entry_t            out_ent_reg;
    logic [ADDR_W-1:0] out_top_reg;
    logic              accept;
    logic              load_out;
    logic              need_low;
    logic              need_high;
    logic              room;
    logic              idx_out_of_range;
    logic [ADDR_W:0]   high_diff;

    assign accept = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign idx_out_of_range = 32'(rd_idx_reg) >= 32'(count_reg);

    assign need_low = start_reg > scan_result.ent.base;
    assign need_high = scan_result.ent.end_addr > req_end_reg;
    assign high_diff = scan_result.ent.end_addr - req_end_reg;
    assign room = (32'(count_reg) + 32'(need_low) + 32'(need_high)) <= TABLE_DEPTH;

    assign query.is_read = (cmd_reg == CMD_READ);
    assign query.rd_idx = IDX_W'(rd_idx_reg);
    assign query.start = start_reg;
    assign query.end_addr = req_end_reg;
    assign query.count = count_reg;

    assign scan_seed = '0;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        top_next = top_reg;
        res_status_next = res_status_reg;
        res_ent_next = res_ent_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        load_out = 1'b0;
        scan_start = 1'b0;
        wr = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = ST_OK;
                    res_ent_next = '0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (cmd_reg)
                    CMD_APPEND:
                    begin
                        if (32'(count_reg) >= TABLE_DEPTH)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            wr.en = 1'b1;
                            wr.idx = IDX_W'(count_reg);
                            wr.ent = '{start_reg, len_reg, kind_reg, req_end_reg};
                            count_next = count_reg + cnt_t'(1);
                            top_next = req_end_reg[ADDR_W-1:0];
                        end
                        state_next = S_DONE;
                    end
                    CMD_RESERVE:
                    begin
                        scan_start = 1'b1;
                        state_next = S_SCAN;
                    end
                    CMD_READ:
                    begin
                        if (idx_out_of_range)
                        begin
                            res_status_next = ST_IDX_RANGE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            scan_start = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    if (cmd_reg == CMD_READ)
                    begin
                        res_ent_next = scan_result.ent;
                        res_ent_next.end_addr = '0;
                        state_next = S_DONE;
                    end
                    else if (!scan_result.hit)
                    begin
                        res_status_next = ST_NO_FIT;
                        state_next = S_DONE;
                    end
                    else if (!room)
                    begin
                        res_status_next = ST_FULL;
                        state_next = S_DONE;
                    end
                    else if (need_low)
                    begin
                        state_next = S_WR_LOW;
                    end
                    else if (need_high)
                    begin
                        state_next = S_WR_HIGH;
                    end
                    else
                    begin
                        state_next = S_WR_FOUND;
                    end
                end
            end
            S_WR_LOW:
            begin
                wr.en = 1'b1;
                wr.idx = IDX_W'(count_reg);
                wr.ent = '{found_reg.ent.base, low_len_reg, KIND_AVAILABLE, {1'b0, start_reg}};
                count_next = count_reg + cnt_t'(1);
                state_next = need_high_reg ? S_WR_HIGH : S_WR_FOUND;
            end
            S_WR_HIGH:
            begin
                // The upper piece starts at the wrapped end of the range, so its own end
                // drops below 2^64 whenever the range end has crossed it.
                wr.en = 1'b1;
                wr.idx = IDX_W'(count_reg);
                wr.ent = '{req_end_reg[ADDR_W-1:0], high_len_reg, KIND_AVAILABLE,
                           req_end_reg[ADDR_W] ?
                               {1'b0, found_reg.ent.end_addr[ADDR_W-1:0]} :
                               found_reg.ent.end_addr};
                count_next = count_reg + cnt_t'(1);
                state_next = S_WR_FOUND;
            end
            S_WR_FOUND:
            begin
                wr.en = 1'b1;
                wr.idx = found_reg.idx;
                wr.ent = '{start_reg, len_reg, KIND_RESERVED, req_end_reg};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            top_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            top_reg <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_ent_reg <= res_ent_next;
        if (accept)
        begin
            cmd_reg <= cmd_t'(req.cmd);
            start_reg <= req.range_base;
            len_reg <= req.range_length;
            kind_reg <= req.region_kind;
            rd_idx_reg <= req.entry_index;
            req_end_reg <= {1'b0, req.range_base} + {1'b0, req.range_length};
        end
        if ((state_reg == S_SCAN) && scan_done)
        begin
            found_reg <= scan_result;
            low_len_reg <= start_reg - scan_result.ent.base;
            high_len_reg <= high_diff[ADDR_W-1:0];
            need_high_reg <= need_high;
        end
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_count_reg <= 5'(count_reg);
            out_ent_reg <= res_ent_reg;
            out_top_reg <= top_reg;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.out_base = out_ent_reg.base;
    assign rsp.out_length = out_ent_reg.length;
    assign rsp.out_kind = out_ent_reg.kind;
    assign rsp.top_addr = out_top_reg;

endmodule

// ----- rtl/memory_region_reserve_table.sv -----
// Top level of the memory region reserve table: sequencer plus a chain of table cells.
// Depends on mrrt_pkg, mrrt_if, mrrt_cell and mrrt_ctrl.
//
// Commands arrive as items on the req channel and each produces one result item on the
// rsp channel; both use a valid/ready handshake and an item moves when both are high.
// Append writes the next free cell. Read and reserve send a query down the row of
// TABLE_DEPTH cells, one cell per cycle; a reserve then writes the leftover low and high
// pieces it needs and marks the found entry reserved. One item is worked on at a time;
// the next item is taken once the current result sits in the output register.
// Reset clears the entry count, the last end address and the output valid flag; table
// entries are not cleared and are only read below the entry count.
// When the receiver holds ready low, the result waits in the output register while the
// block accepts and executes the next item, which then waits until that register frees.
module memory_region_reserve_table
    import mrrt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    mrrt_req_if.sink   req,
    mrrt_rsp_if.source rsp
);

    query_t             query;
    write_t             wr;
    logic               scan_start;
    scan_t              scan_seed;
    logic [TABLE_DEPTH:0] chain_valid;
    scan_t              chain_data [0:TABLE_DEPTH];

    mrrt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .query       (query),
        .wr          (wr),
        .scan_start  (scan_start),
        .scan_seed   (scan_seed),
        .scan_done   (chain_valid[TABLE_DEPTH]),
        .scan_result (chain_data[TABLE_DEPTH])
    );

    assign chain_valid[0] = scan_start;
    assign chain_data[0] = scan_seed;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        mrrt_cell u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .cell_idx       (IDX_W'(i)),
            .query          (query),
            .wr             (wr),
            .scan_in_valid  (chain_valid[i]),
            .scan_in        (chain_data[i]),
            .scan_out_valid (chain_valid[i+1]),
            .scan_out       (chain_data[i+1])
        );
    end

    a_range_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ST_IDX_RANGE) |->
            (rsp.out_base == '0) && (rsp.out_length == '0) && (rsp.out_kind == '0))
        else $error("Out-of-range read returned nonzero entry fields.");

    a_scan_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[TABLE_DEPTH] |-> !req.ready)
        else $error("Scan finished while the block was taking a new item.");

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("A second item was taken before the first was executed.");

    a_write_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> !req.ready && !chain_valid[TABLE_DEPTH])
        else $error("Table write outside a command's write phase.");

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for memory_region_reserve_table: directed table walk, then random
// commands against an in-bench model of the region table, with random idles on both sides.
// Depends on mrrt_pkg, mrrt_req_if, mrrt_rsp_if and the memory_region_reserve_table RTL.
module tb_top;
    import mrrt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1000;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES = TABLE_DEPTH + 10;

    typedef struct packed {
        status_t     status;
        logic [4:0]  count;
        logic [63:0] base;
        logic [63:0] length;
        logic [7:0]  kind;
        logic [63:0] top;
    } region_result_t;

    typedef struct packed {
        cmd_t           cmd;
        logic [63:0]    base;
        logic [63:0]    length;
        logic [7:0]     kind;
        logic [3:0]     idx;
        bit             typed;
        region_result_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    mrrt_req_if req_ch();
    mrrt_rsp_if rsp_ch();

    memory_region_reserve_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic [63:0] tbl_base [TABLE_DEPTH];
    logic [63:0] tbl_len [TABLE_DEPTH];
    logic [7:0]  tbl_kind [TABLE_DEPTH];
    int          tbl_count;
    logic [63:0] tbl_top;

    region_result_t pending_results [$];
    stim_row_t      directed_rows [$];

    int  errors;
    int  results_checked;
    int  cmd_seen [4];
    int  status_seen [4];
    int  idle_cycles;
    bit  steady;

    int          n;
    int          pick;
    int          slot;
    cmd_t        rnd_cmd;
    logic [63:0] rnd_base;
    logic [63:0] rnd_len;
    logic [64:0] span;
    logic [64:0] offset;
    logic [64:0] room;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_addr();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 64'd0;
        else if (r == 1)
            return '1;
        return rand64();
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic region_result_t apply_cmd(input cmd_t c, input logic [63:0] b,
                                                 input logic [63:0] l, input logic [7:0] k,
                                                 input logic [3:0] idx);
        region_result_t r;
        int             found;
        logic [64:0]    req_end;
        logic [64:0]    ent_end;
        logic [63:0]    fb;
        logic [63:0]    fl;
        logic [63:0]    low;
        logic [63:0]    used;
        bit             need_low;
        bit             need_high;
        int             pieces;
        r = '0;
        r.status = ST_OK;
        found = -1;
        case (c)
            CMD_APPEND:
            begin
                if (tbl_count >= TABLE_DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    tbl_base[tbl_count] = b;
                    tbl_len[tbl_count] = l;
                    tbl_kind[tbl_count] = k;
                    tbl_count++;
                    tbl_top = b + l;
                end
            end
            CMD_RESERVE:
            begin
                req_end = {1'b0, b} + {1'b0, l};
                for (int i = 0; i < tbl_count; i++)
                begin
                    ent_end = {1'b0, tbl_base[i]} + {1'b0, tbl_len[i]};
                    if (found < 0 && tbl_kind[i] == KIND_AVAILABLE && tbl_base[i] <= b &&
                        req_end <= ent_end)
                        found = i;
                end
                if (found < 0)
                begin
                    r.status = ST_NO_FIT;
                end
                else
                begin
                    fb = tbl_base[found];
                    fl = tbl_len[found];
                    low = b - fb;
                    used = low + l;
                    need_low = b > fb;
                    need_high = fl > used;
                    pieces = int'(need_low) + int'(need_high);
                    if (tbl_count + pieces > TABLE_DEPTH)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        if (need_low)
                        begin
                            tbl_base[tbl_count] = fb;
                            tbl_len[tbl_count] = low;
                            tbl_kind[tbl_count] = KIND_AVAILABLE;
                            tbl_count++;
                        end
                        if (need_high)
                        begin
                            tbl_base[tbl_count] = b + l;
                            tbl_len[tbl_count] = fl - used;
                            tbl_kind[tbl_count] = KIND_AVAILABLE;
                            tbl_count++;
                        end
                        tbl_base[found] = b;
                        tbl_len[found] = l;
                        tbl_kind[found] = KIND_RESERVED;
                    end
                end
            end
            CMD_READ:
            begin
                if (idx >= tbl_count)
                begin
                    r.status = ST_IDX_RANGE;
                end
                else
                begin
                    r.base = tbl_base[idx];
                    r.length = tbl_len[idx];
                    r.kind = tbl_kind[idx];
                end
            end
            default:
            begin
            end
        endcase
        r.count = 5'(tbl_count);
        r.top = tbl_top;
        return r;
    endfunction

    task automatic add_row(input cmd_t c, input logic [63:0] b, input logic [63:0] l,
                           input logic [7:0] k, input logic [3:0] idx, input bit typed,
                           input status_t st, input logic [4:0] cnt, input logic [63:0] ob,
                           input logic [63:0] ol, input logic [7:0] ok,
                           input logic [63:0] top);
        stim_row_t row;
        row.cmd = c;
        row.base = b;
        row.length = l;
        row.kind = k;
        row.idx = idx;
        row.typed = typed;
        row.want.status = st;
        row.want.count = cnt;
        row.want.base = ob;
        row.want.length = ol;
        row.want.kind = ok;
        row.want.top = top;
        directed_rows.push_back(row);
    endtask

    // Called at a falling edge; returns at a falling edge after the item and its idle gap.
    task automatic issue_cmd(input cmd_t c, input logic [63:0] b, input logic [63:0] l,
                             input logic [7:0] k, input logic [3:0] idx, input bit typed,
                             input region_result_t want);
        region_result_t predicted;
        int             gap;
        req_ch.cmd <= c;
        req_ch.range_base <= b;
        req_ch.range_length <= l;
        req_ch.region_kind <= k;
        req_ch.entry_index <= idx;
        req_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = apply_cmd(c, b, l, k, idx);
        cmd_seen[int'(c)]++;
        status_seen[int'(predicted.status)]++;
        pending_results.push_back(typed ? want : predicted);
        @(negedge clk);
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch in result %0d, %s: got %h, expected %h",
                 results_checked, field, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        region_result_t w;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("result item arrived with nothing outstanding");
                errors++;
            end
            else
            begin
                w = pending_results.pop_front();
                if (rsp_ch.status !== w.status)
                    report_mismatch("status", 64'(rsp_ch.status), 64'(w.status));
                if (rsp_ch.entry_count !== w.count)
                    report_mismatch("entry_count", 64'(rsp_ch.entry_count), 64'(w.count));
                if (rsp_ch.out_base !== w.base)
                    report_mismatch("out_base", rsp_ch.out_base, w.base);
                if (rsp_ch.out_length !== w.length)
                    report_mismatch("out_length", rsp_ch.out_length, w.length);
                if (rsp_ch.out_kind !== w.kind)
                    report_mismatch("out_kind", 64'(rsp_ch.out_kind), 64'(w.kind));
                if (rsp_ch.top_addr !== w.top)
                    report_mismatch("top_addr", rsp_ch.top_addr, w.top);
                results_checked++;
            end
        end
    end

    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (steady)
            begin
                rsp_ch.ready <= 1'b1;
                stall = 0;
            end
            else if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else if ($urandom_range(0, 9) < 7)
            begin
                rsp_ch.ready <= 1'b1;
            end
            else
            begin
                rsp_ch.ready <= 1'b0;
                stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("memory_region_reserve_table regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_NOP;
        req_ch.range_base = '0;
        req_ch.range_length = '0;
        req_ch.region_kind = '0;
        req_ch.entry_index = '0;
        errors = 0;
        results_checked = 0;
        idle_cycles = 0;
        steady = 1'b0;
        tbl_count = 0;
        tbl_top = '0;
        foreach (cmd_seen[i])
            cmd_seen[i] = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        foreach (tbl_base[i])
        begin
            tbl_base[i] = '0;
            tbl_len[i] = '0;
            tbl_kind[i] = '0;
        end

        add_row(CMD_READ, 0, 0, 0, 0, 1, ST_IDX_RANGE, 0, 0, 0, 0, 0);
        add_row(CMD_RESERVE, 0, 0, 0, 0, 1, ST_NO_FIT, 0, 0, 0, 0, 0);
        add_row(CMD_NOP, '1, '1, 8'hFF, 4'hF, 1, ST_OK, 0, 0, 0, 0, 0);
        add_row(CMD_APPEND, 64'h1000, 64'h1000, KIND_AVAILABLE, 0, 1, ST_OK, 1, 0, 0, 0,
                64'h2000);
        add_row(CMD_APPEND, 64'hFFFF_FFFF_FFFF_F000, 64'h2000, KIND_AVAILABLE, 0, 1, ST_OK, 2,
                0, 0, 0, 64'h1000);
        add_row(CMD_APPEND, 0, 0, 8'hFF, 0, 1, ST_OK, 3, 0, 0, 0, 0);
        add_row(CMD_READ, 0, 0, 0, 1, 1, ST_OK, 3, 64'hFFFF_FFFF_FFFF_F000, 64'h2000,
                KIND_AVAILABLE, 0);
        add_row(CMD_RESERVE, 64'h1800, 64'h100, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0);
        add_row(CMD_RESERVE, 64'hFFFF_FFFF_FFFF_F800, 64'h1000, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0);
        add_row(CMD_RESERVE, 64'h1000, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0);
        add_row(CMD_RESERVE, 64'h1000, 64'h1_0000, 0, 0, 1, ST_NO_FIT, 8, 0, 0, 0, 0);
        add_row(CMD_APPEND, '1, '1, KIND_AVAILABLE, 0, 1, ST_OK, 9, 0, 0, 0,
                64'hFFFF_FFFF_FFFF_FFFE);
        add_row(CMD_READ, 0, 0, 0, 4'hF, 1, ST_IDX_RANGE, 9, 0, 0, 0,
                64'hFFFF_FFFF_FFFF_FFFE);
        add_row(CMD_RESERVE, '1, '1, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0);
        add_row(CMD_READ, 0, 0, 0, 8, 0, ST_OK, 0, 0, 0, 0, 0);
        add_row(CMD_APPEND, 64'h10_0000, 64'h10_0000, KIND_AVAILABLE, 0, 0, ST_OK, 0, 0, 0, 0, 0);
        add_row(CMD_APPEND, 64'h4000_0000, 64'h4000_0000, KIND_AVAILABLE, 0, 0, ST_OK, 0, 0, 0,
                0, 0);
        add_row(CMD_APPEND, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, KIND_AVAILABLE,
                0, 0, ST_OK, 0, 0, 0, 0, 0);
        add_row(CMD_APPEND, 64'h30_0000, 0, KIND_AVAILABLE, 0, 0, ST_OK, 0, 0, 0, 0, 0);
        add_row(CMD_APPEND, 64'h1_0000_0000, 64'h1_0000, 8'h5A, 0, 0, ST_OK, 0, 0, 0, 0, 0);
        add_row(CMD_APPEND, 64'h50_0000, 64'h1000, KIND_AVAILABLE, 0, 0, ST_OK, 0, 0, 0, 0, 0);
        add_row(CMD_APPEND, 64'h60_0000, 64'h1000, KIND_AVAILABLE, 0, 0, ST_OK, 0, 0, 0, 0, 0);
        add_row(CMD_APPEND, 64'h70_0000, 64'h10, KIND_AVAILABLE, 0, 1, ST_FULL, 16, 0, 0, 0,
                64'h60_1000);
        add_row(CMD_RESERVE, 64'h10_0800, 64'h100, 0, 0, 1, ST_FULL, 16, 0, 0, 0, 64'h60_1000);
        add_row(CMD_RESERVE, 64'h50_0000, 64'h1000, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            issue_cmd(directed_rows[i].cmd, directed_rows[i].base, directed_rows[i].length,
                      directed_rows[i].kind, directed_rows[i].idx, directed_rows[i].typed,
                      directed_rows[i].want);

        // The table is full from here on, so well-formed reserves mostly take whole entries
        // or sub-ranges that must be refused for lack of room.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 128 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_ITEMS / 2)
            begin
                req_ch.valid <= 1'b0;
                do
                    @(negedge clk);
                while (pending_results.size() != 0);
            end
            pick = $urandom_range(0, 99);
            rnd_base = pick_addr();
            rnd_len = pick_addr();
            if (pick < 35 && tbl_count > 0)
            begin
                rnd_cmd = CMD_RESERVE;
                slot = $urandom_range(0, tbl_count - 1);
                if ($urandom_range(0, 9) < 4)
                begin
                    rnd_base = tbl_base[slot];
                    rnd_len = tbl_len[slot];
                end
                else
                begin
                    span = {1'b0, tbl_len[slot]} + 65'd1;
                    offset = {1'b0, rand64()} % span;
                    room = {1'b0, tbl_len[slot]} - offset + 65'd1;
                    rnd_base = tbl_base[slot] + offset[63:0];
                    rnd_len = 64'({1'b0, rand64()} % room);
                end
            end
            else if (pick < 65)
                rnd_cmd = CMD_READ;
            else if (pick < 75)
                rnd_cmd = CMD_APPEND;
            else if (pick < 87)
                rnd_cmd = CMD_RESERVE;
            else
                rnd_cmd = CMD_NOP;
            issue_cmd(rnd_cmd, rnd_base, rnd_len, 8'($urandom_range(0, 255)),
                      4'($urandom_range(0, 15)), 0, '0);
        end

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0d results never arrived", pending_results.size());
            errors += pending_results.size();
        end

        $display("covered %0d append, %0d reserve, %0d read and %0d no-op commands; %0d results checked",
                 cmd_seen[CMD_APPEND], cmd_seen[CMD_RESERVE], cmd_seen[CMD_READ],
                 cmd_seen[CMD_NOP], results_checked);
        $display("outcomes: %0d ok, %0d without fit, %0d table full, %0d index out of range",
                 status_seen[ST_OK], status_seen[ST_NO_FIT], status_seen[ST_FULL],
                 status_seen[ST_IDX_RANGE]);
        if (errors == 0)
            $display("memory_region_reserve_table regression: pass");
        else
            $display("memory_region_reserve_table regression: fail");
        $finish;
    end

endmodule

// ----- memory_region_reserve_table.f -----
rtl/mrrt_pkg.sv
rtl/mrrt_if.sv
rtl/mrrt_cell.sv
rtl/mrrt_ctrl.sv
rtl/memory_region_reserve_table.sv
tb/sv/tb_top.sv
